FILE: rtl/sprite_background_pixel_compositor_assert.svh
// Assertion helpers shared by the compositor RTL.
// Both expect clk and rst_n in scope.
`ifndef SPRITE_BACKGROUND_PIXEL_COMPOSITOR_ASSERT_SVH
`define SPRITE_BACKGROUND_PIXEL_COMPOSITOR_ASSERT_SVH

// same-cycle implication
`define SBPC_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbpc assertion failed");

// next-cycle implication
`define SBPC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbpc assertion failed");

`endif

FILE: rtl/sbpc_pkg.sv
package sbpc_pkg;

  localparam int SPRITE_LAYERS = 4;
  localparam int BG_LAYERS     = 4;
  localparam int CHAN_W        = 5;
  localparam int NUM_CHAN      = 3;

  localparam int PRESENT_BIT   = 15;
  localparam int BACKDROP_TGT  = 5;

  localparam logic [CHAN_W-1:0] CHAN_MAX        = 5'h1F;
  localparam logic [2:0]        BACKDROP_PRIO   = 3'd4;
  localparam logic [3:0]        OBJ_WINNER_BASE = 4'd5;

  // config register indexes
  localparam logic [2:0] CFG_BG_PRIO   = 3'd0;
  localparam logic [2:0] CFG_BG_EN     = 3'd1;
  localparam logic [2:0] CFG_TGT_MASK  = 3'd2;
  localparam logic [2:0] CFG_ALPHA_A   = 3'd3;
  localparam logic [2:0] CFG_ALPHA_B   = 3'd4;
  localparam logic [2:0] CFG_BACKDROP  = 3'd5;

  typedef logic [15:0] color_t;
  typedef logic [BG_LAYERS-1:0][15:0] layer_arr_t;
  typedef logic [CHAN_W-1:0] alpha_t;

  typedef struct packed {
    logic   found;
    color_t color;
  } sbpc_tgt_t;

  // two-bit priority of background n
  function automatic logic [1:0] bg_prio(input logic [7:0] pack, input logic [1:0] n);
    bg_prio = pack[{n, 1'b0} +: 2];
  endfunction

endpackage

FILE: rtl/sbpc_target.sv
module sbpc_target (
  input  logic [1:0]             start_prio,
  input  sbpc_pkg::layer_arr_t   layers,
  input  logic [7:0]             prio_pack,
  input  logic [3:0]             en_mask,
  input  logic [5:0]             tgt_mask,
  input  sbpc_pkg::color_t       backdrop,
  output sbpc_pkg::sbpc_tgt_t    tgt
);
  import sbpc_pkg::*;

  logic [BG_LAYERS-1:0] same_hit;
  logic [BG_LAYERS-1:0] later;
  logic [1:0]           prio [BG_LAYERS];
  logic                 same_found;
  logic [1:0]           same_n;
  logic                 best_vld;
  logic [1:0]           best_n;
  logic [1:0]           best_p;

  always_comb begin
    for (int n = 0; n < BG_LAYERS; n++) begin
      prio[n]     = bg_prio(prio_pack, 2'(n));
      same_hit[n] = layers[n][PRESENT_BIT] & en_mask[n] & tgt_mask[n] &
                    (prio[n] == start_prio);
      later[n]    = layers[n][PRESENT_BIT] & en_mask[n] & (prio[n] > start_prio);
    end
  end

  // first target at the sprite's own priority, lowest background wins
  always_comb begin
    same_found = 1'b0;
    same_n     = '0;
    for (int n = BG_LAYERS - 1; n >= 0; n--) begin
      if (same_hit[n]) begin
        same_found = 1'b1;
        same_n     = 2'(n);
      end
    end
  end

  // first live layer behind the sprite, ordered by (priority, index)
  always_comb begin
    best_vld = 1'b0;
    best_n   = '0;
    best_p   = '0;
    for (int n = 0; n < BG_LAYERS; n++) begin
      if (later[n] && (!best_vld || prio[n] < best_p)) begin
        best_vld = 1'b1;
        best_n   = 2'(n);
        best_p   = prio[n];
      end
    end
  end

  always_comb begin
    if (same_found) begin
      tgt.found = 1'b1;
      tgt.color = layers[same_n];
    end else if (best_vld) begin
      // an opaque layer that is not a target hides everything below
      tgt.found = tgt_mask[best_n];
      tgt.color = layers[best_n];
    end else begin
      tgt.found = tgt_mask[BACKDROP_TGT];
      tgt.color = backdrop;
    end
  end

endmodule

FILE: rtl/sbpc_blend.sv
module sbpc_blend (
  input  sbpc_pkg::color_t color_a,
  input  sbpc_pkg::color_t color_b,
  input  sbpc_pkg::alpha_t alpha_a,
  input  sbpc_pkg::alpha_t alpha_b,
  output sbpc_pkg::color_t color_out
);
  import sbpc_pkg::*;

  logic [2*CHAN_W-1:0] prod_a [NUM_CHAN];
  logic [2*CHAN_W-1:0] prod_b [NUM_CHAN];
  logic [2*CHAN_W:0]   sum    [NUM_CHAN];
  logic [2*CHAN_W-4:0] scaled [NUM_CHAN];

  always_comb begin
    color_out = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      prod_a[c] = {{CHAN_W{1'b0}}, color_a[c*CHAN_W +: CHAN_W]} *
                  {{CHAN_W{1'b0}}, alpha_a};
      prod_b[c] = {{CHAN_W{1'b0}}, color_b[c*CHAN_W +: CHAN_W]} *
                  {{CHAN_W{1'b0}}, alpha_b};
      sum[c]    = {1'b0, prod_a[c]} + {1'b0, prod_b[c]};
      scaled[c] = sum[c][2*CHAN_W:4];
      color_out[c*CHAN_W +: CHAN_W] = (scaled[c] > {2'b00, CHAN_MAX}) ?
                                      CHAN_MAX : scaled[c][CHAN_W-1:0];
    end
    color_out[PRESENT_BIT] = 1'b1;
  end

endmodule

FILE: rtl/sprite_background_pixel_compositor.sv
// Pixel compositor: takes one pixel per clock and never pushes back, so busy
// stays low and a request is taken at every clock edge with start high. Each
// request yields exactly one result on out_pixel_color / out_final_winner,
// flagged by out_valid for one cycle, after it passes the input register and
// then the result register; results come out in request order and the
// receiver must take them as they appear. Configuration registers are written
// through cfg_valid / cfg_ready (always ready); write them only while no pixel
// is in flight, since the compositing logic reads them live.
module sprite_background_pixel_compositor (
  input  logic                 clk,
  input  logic                 rst_n,
  // pixel requests
  input  logic                 start,
  output logic                 busy,
  input  sbpc_pkg::color_t     in_bg_color,
  input  logic [2:0]           in_bg_winner,
  input  sbpc_pkg::color_t     in_obj_color0,
  input  sbpc_pkg::color_t     in_obj_color1,
  input  sbpc_pkg::color_t     in_obj_color2,
  input  sbpc_pkg::color_t     in_obj_color3,
  input  logic [3:0]           in_obj_semi_mask,
  input  sbpc_pkg::color_t     in_bg_layer0_color,
  input  sbpc_pkg::color_t     in_bg_layer1_color,
  input  sbpc_pkg::color_t     in_bg_layer2_color,
  input  sbpc_pkg::color_t     in_bg_layer3_color,
  // results
  output logic                 out_valid,
  output sbpc_pkg::color_t     out_pixel_color,
  output logic [3:0]           out_final_winner,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import sbpc_pkg::*;

  // ---------------- configuration registers ----------------
  logic [7:0]  bg_prio_r;
  logic [3:0]  bg_en_r;
  logic [5:0]  tgt_mask_r;
  alpha_t      alpha_a_r;
  alpha_t      alpha_b_r;
  color_t      backdrop_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_prio_r  <= '0;
      bg_en_r    <= '0;
      tgt_mask_r <= '0;
      alpha_a_r  <= 5'd16;
      alpha_b_r  <= '0;
      backdrop_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BG_PRIO:  bg_prio_r  <= cfg_data[7:0];
        CFG_BG_EN:    bg_en_r    <= cfg_data[3:0];
        CFG_TGT_MASK: tgt_mask_r <= cfg_data[5:0];
        CFG_ALPHA_A:  alpha_a_r  <= cfg_data[CHAN_W-1:0];
        CFG_ALPHA_B:  alpha_b_r  <= cfg_data[CHAN_W-1:0];
        CFG_BACKDROP: backdrop_r <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------- input register ----------------
  logic       accept;
  logic       s1_valid_r;
  color_t     bg_color_r;
  logic [2:0] bg_winner_r;
  logic [SPRITE_LAYERS-1:0][15:0] obj_r;
  logic [SPRITE_LAYERS-1:0]       semi_r;
  layer_arr_t layers_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bg_color_r  <= in_bg_color;
      bg_winner_r <= in_bg_winner;
      obj_r       <= {in_obj_color3, in_obj_color2, in_obj_color1, in_obj_color0};
      semi_r      <= in_obj_semi_mask;
      layers_r    <= {in_bg_layer3_color, in_bg_layer2_color,
                      in_bg_layer1_color, in_bg_layer0_color};
    end
  end

  // ---------------- compositing ----------------
  logic        obj_present;
  logic [1:0]  sel;
  logic [2:0]  bg_side_prio;
  logic        obj_wins;
  sbpc_tgt_t   tgt;
  color_t      blended;
  color_t      obj_pix;
  color_t      pixel_nxt;
  logic [3:0]  winner_nxt;

  // foremost present sprite layer
  always_comb begin
    obj_present = 1'b0;
    sel         = '0;
    for (int k = SPRITE_LAYERS - 1; k >= 0; k--) begin
      if (obj_r[k][PRESENT_BIT]) begin
        obj_present = 1'b1;
        sel         = 2'(k);
      end
    end
  end

  // backdrop and out-of-range winners rank below every sprite
  always_comb begin
    if (bg_winner_r >= 3'd1 && bg_winner_r <= 3'd4) begin
      bg_side_prio = {1'b0, bg_prio(bg_prio_r, 2'(bg_winner_r - 3'd1))};
    end else begin
      bg_side_prio = BACKDROP_PRIO;
    end
  end

  assign obj_wins = obj_present && ({1'b0, sel} <= bg_side_prio);
  assign obj_pix  = obj_r[sel];

  sbpc_target u_target (
    .start_prio (sel),
    .layers     (layers_r),
    .prio_pack  (bg_prio_r),
    .en_mask    (bg_en_r),
    .tgt_mask   (tgt_mask_r),
    .backdrop   (backdrop_r),
    .tgt        (tgt)
  );

  sbpc_blend u_blend (
    .color_a   (obj_pix),
    .color_b   (tgt.color),
    .alpha_a   (alpha_a_r),
    .alpha_b   (alpha_b_r),
    .color_out (blended)
  );

  always_comb begin
    if (obj_wins) begin
      pixel_nxt  = (semi_r[sel] && tgt.found) ? blended : obj_pix;
      winner_nxt = OBJ_WINNER_BASE + {2'b00, sel};
    end else begin
      pixel_nxt  = bg_color_r;
      winner_nxt = {1'b0, bg_winner_r};
    end
  end

  // ---------------- result register ----------------
  logic        out_valid_r;
  color_t      pixel_r;
  logic [3:0]  winner_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      pixel_r  <= pixel_nxt;
      winner_r <= winner_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_color  = pixel_r;
  assign out_final_winner = winner_r;

  // ---------------- checks ----------------
`include "sprite_background_pixel_compositor_assert.svh"

  // every result traces back to an accepted request
  `SBPC_ASSERT_IMPL(a_out_has_req, out_valid, $past(accept, 2))
  // staged pixel always reaches the output
  `SBPC_ASSERT_NEXT(a_stage_flow, s1_valid_r, out_valid)
  // a sprite result is either an opaque sprite pixel or a blend: bit 15 set
  `SBPC_ASSERT_IMPL(a_obj_bit15, out_valid && $past(obj_wins), out_pixel_color[PRESENT_BIT])
  // background side passes the resolved color through untouched
  `SBPC_ASSERT_IMPL(a_bg_pass, out_valid && (out_final_winner < OBJ_WINNER_BASE),
                    out_pixel_color == $past(in_bg_color, 2))

endmodule

FILE: tb/sv/sprite_background_pixel_compositor_tb.sv
`timescale 1ns / 1ps

module sprite_background_pixel_compositor_tb;
  import sbpc_pkg::*;

  // cycles with no request, result or register write before the run is called hung
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int MAX_REPORTS     = 10;

  // final_winner codes
  localparam logic [3:0] WIN_BACKDROP = 4'd0;
  localparam logic [3:0] WIN_BG0      = 4'd1;
  localparam logic [3:0] WIN_BG3      = 4'd4;
  localparam logic [3:0] WIN_OBJ0     = OBJ_WINNER_BASE;
  localparam logic [3:0] WIN_OBJ2     = OBJ_WINNER_BASE + 4'd2;
  localparam logic [3:0] WIN_OBJ3     = OBJ_WINNER_BASE + 4'd3;

  // one pixel request, sprite layers and background layers indexed 0..3
  typedef struct packed {
    color_t           bg_color;
    logic [2:0]       bg_winner;
    logic [3:0][15:0] obj;
    logic [3:0]       semi;
    logic [3:0][15:0] layer;
  } pixel_req_t;

  typedef struct packed {
    color_t     color;
    logic [3:0] winner;
  } pixel_res_t;

  typedef enum logic { ROW_PIXEL, ROW_CFG } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [2:0] reg_idx;
    logic [15:0] reg_data;
    pixel_req_t req;
    logic       has_exp;
    pixel_res_t exp;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  color_t     in_bg_color = '0;
  logic [2:0] in_bg_winner = '0;
  color_t     in_obj_color0 = '0;
  color_t     in_obj_color1 = '0;
  color_t     in_obj_color2 = '0;
  color_t     in_obj_color3 = '0;
  logic [3:0] in_obj_semi_mask = '0;
  color_t     in_bg_layer0_color = '0;
  color_t     in_bg_layer1_color = '0;
  color_t     in_bg_layer2_color = '0;
  color_t     in_bg_layer3_color = '0;
  logic       out_valid;
  color_t     out_pixel_color;
  logic [3:0] out_final_winner;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // typed-in expectation that travels with the request on the pins
  logic       row_has_exp = 1'b0;
  pixel_res_t row_exp = '0;

  // shadow copy of the configuration registers, reset values
  logic [7:0] cfg_bg_prio  = 8'h00;
  logic [3:0] cfg_bg_en    = 4'h0;
  logic [5:0] cfg_tgt_mask = 6'h00;
  alpha_t     cfg_alpha_a  = 5'd16;
  alpha_t     cfg_alpha_b  = 5'd0;
  color_t     cfg_backdrop = 16'h0000;

  pixel_res_t expected_pixels[$];
  dir_row_t   directed_rows[$];
  int         error_count = 0;
  int         stall_cycles = 0;

  always #5 clk = ~clk;

  sprite_background_pixel_compositor DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_bg_color        (in_bg_color),
    .in_bg_winner       (in_bg_winner),
    .in_obj_color0      (in_obj_color0),
    .in_obj_color1      (in_obj_color1),
    .in_obj_color2      (in_obj_color2),
    .in_obj_color3      (in_obj_color3),
    .in_obj_semi_mask   (in_obj_semi_mask),
    .in_bg_layer0_color (in_bg_layer0_color),
    .in_bg_layer1_color (in_bg_layer1_color),
    .in_bg_layer2_color (in_bg_layer2_color),
    .in_bg_layer3_color (in_bg_layer3_color),
    .out_valid          (out_valid),
    .out_pixel_color    (out_pixel_color),
    .out_final_winner   (out_final_winner),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Compositing predictor
  // ---------------------------------------------------------------------------

  function automatic logic [1:0] prio_of(input int n);
    return cfg_bg_prio[2*n +: 2];
  endfunction

  // Second target search. Walks priorities from the sprite's own level down;
  // a live (opaque and enabled) background that is not a target ends the walk,
  // except on the sprite's own level. Falls back to the backdrop if enabled.
  function automatic sbpc_tgt_t find_target(input logic [3:0][15:0] layers, input int first);
    sbpc_tgt_t t;
    logic      live;
    t = '0;
    for (int p = first; p <= 3; p++) begin
      for (int n = 0; n < BG_LAYERS; n++) begin
        if (prio_of(n) == p) begin
          live = layers[n][PRESENT_BIT] && cfg_bg_en[n];
          if (live && cfg_tgt_mask[n]) begin
            t.found = 1'b1;
            t.color = layers[n];
            return t;
          end
          if (live && p != first) return t;
        end
      end
    end
    // mask bit 4 is not looked at anywhere
    if (cfg_tgt_mask[BACKDROP_TGT]) begin
      t.found = 1'b1;
      t.color = cfg_backdrop;
    end
    return t;
  endfunction

  // per-channel weighted sum in sixteenths, saturating at full scale
  function automatic color_t mix_colors(input color_t a, input color_t b);
    color_t      c;
    int unsigned ca, cb, v;
    c = '0;
    c[PRESENT_BIT] = 1'b1;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      ca = a[ch*CHAN_W +: CHAN_W];
      cb = b[ch*CHAN_W +: CHAN_W];
      v = (ca * cfg_alpha_a + cb * cfg_alpha_b) >> 4;
      c[ch*CHAN_W +: CHAN_W] = (v > CHAN_MAX) ? CHAN_MAX : v[CHAN_W-1:0];
    end
    return c;
  endfunction

  function automatic pixel_res_t composite_pixel(input pixel_req_t r);
    pixel_res_t res;
    sbpc_tgt_t  tgt;
    int         sel;
    int         bg_front;
    sel = SPRITE_LAYERS;
    for (int k = SPRITE_LAYERS - 1; k >= 0; k--) begin
      if (r.obj[k][PRESENT_BIT]) sel = k;
    end
    // out-of-range winner codes rank like the backdrop
    if (r.bg_winner >= 3'd1 && r.bg_winner <= 3'd4) bg_front = prio_of(r.bg_winner - 1);
    else bg_front = BACKDROP_PRIO;
    if (sel < SPRITE_LAYERS && sel <= bg_front) begin
      res.color = r.obj[sel];
      if (r.semi[sel]) begin
        tgt = find_target(r.layer, sel);
        if (tgt.found) res.color = mix_colors(res.color, tgt.color);
      end
      res.winner = OBJ_WINNER_BASE + 4'(sel);
    end else begin
      res.color = r.bg_color;
      res.winner = {1'b0, r.bg_winner};
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: every accepted request and register write is taken from the pins
  // at the edge that accepts it, so the shadow registers and the expectation
  // queue follow the block exactly; results are checked in the same process.
  // ---------------------------------------------------------------------------

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : check_pixels
    pixel_req_t seen;
    pixel_res_t want;
    logic       progress;
    if (rst_n) begin
      progress = 1'b0;
      if (cfg_valid && cfg_ready) begin
        progress = 1'b1;
        case (cfg_index)
          CFG_BG_PRIO:  cfg_bg_prio  = cfg_data[7:0];
          CFG_BG_EN:    cfg_bg_en    = cfg_data[3:0];
          CFG_TGT_MASK: cfg_tgt_mask = cfg_data[5:0];
          CFG_ALPHA_A:  cfg_alpha_a  = cfg_data[4:0];
          CFG_ALPHA_B:  cfg_alpha_b  = cfg_data[4:0];
          CFG_BACKDROP: cfg_backdrop = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        progress = 1'b1;
        seen.bg_color  = in_bg_color;
        seen.bg_winner = in_bg_winner;
        seen.obj       = {in_obj_color3, in_obj_color2, in_obj_color1, in_obj_color0};
        seen.semi      = in_obj_semi_mask;
        seen.layer     = {in_bg_layer3_color, in_bg_layer2_color,
                          in_bg_layer1_color, in_bg_layer0_color};
        expected_pixels.push_back(row_has_exp ? row_exp : composite_pixel(seen));
      end
      if (out_valid) begin
        progress = 1'b1;
        if (expected_pixels.size() == 0) begin
          flag_error($sformatf("unexpected result color=%h winner=%0d",
                               out_pixel_color, out_final_winner));
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_color !== want.color || out_final_winner !== want.winner)
            flag_error($sformatf("mismatch: expected color=%h winner=%0d, got color=%h winner=%0d",
                                 want.color, want.winner, out_pixel_color, out_final_winner));
        end
      end
      stall_cycles = progress ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------

  // Present one request, after a random number of idle cycles. start stays
  // high after acceptance so back-to-back requests need no extra assignment.
  task automatic send_pixel(input pixel_req_t r, input int idle_pct,
                            input logic has_exp, input pixel_res_t exp_res);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start              <= 1'b1;
    in_bg_color        <= r.bg_color;
    in_bg_winner       <= r.bg_winner;
    in_obj_color0      <= r.obj[0];
    in_obj_color1      <= r.obj[1];
    in_obj_color2      <= r.obj[2];
    in_obj_color3      <= r.obj[3];
    in_obj_semi_mask   <= r.semi;
    in_bg_layer0_color <= r.layer[0];
    in_bg_layer1_color <= r.layer[1];
    in_bg_layer2_color <= r.layer[2];
    in_bg_layer3_color <= r.layer[3];
    row_has_exp        <= has_exp;
    row_exp            <= exp_res;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // stop issuing and wait until every outstanding pixel has come back
  task automatic drain_pixels();
    start <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] prio, input logic [3:0] en, input logic [5:0] mask,
                           input alpha_t aa, input alpha_t ab, input color_t bd);
    drain_pixels();
    write_reg(CFG_BG_PRIO, {8'h00, prio});
    write_reg(CFG_BG_EN, {12'h000, en});
    write_reg(CFG_TGT_MASK, {10'h000, mask});
    write_reg(CFG_ALPHA_A, {11'h000, aa});
    write_reg(CFG_ALPHA_B, {11'h000, ab});
    write_reg(CFG_BACKDROP, bd);
  endtask

  function automatic pixel_req_t make_req(input color_t bgc, input logic [2:0] bgw,
                                          input color_t o0, o1, o2, o3, input logic [3:0] semi,
                                          input color_t l0, l1, l2, l3);
    pixel_req_t r;
    r.bg_color  = bgc;
    r.bg_winner = bgw;
    r.obj       = {o3, o2, o1, o0};
    r.semi      = semi;
    r.layer     = {l3, l2, l1, l0};
    return r;
  endfunction

  task automatic add_cfg_row(input logic [2:0] idx, input logic [15:0] data);
    dir_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.reg_data = data;
    directed_rows.push_back(row);
  endtask

  task automatic add_pixel_row(input pixel_req_t r, input logic has_exp,
                               input color_t color, input logic [3:0] winner);
    dir_row_t row;
    row = '0;
    row.kind = ROW_PIXEL;
    row.req = r;
    row.has_exp = has_exp;
    row.exp.color = color;
    row.exp.winner = winner;
    directed_rows.push_back(row);
  endtask

  // Random pixel, mostly well formed: the first present sprite sits at a
  // chosen layer, layers in front of it are absent, and its semi bit is
  // usually set so the blend path and the target walk get exercised.
  function automatic pixel_req_t random_pixel();
    pixel_req_t r;
    int         front;
    front = $urandom_range(0, 4);
    r.bg_color = 16'($urandom);
    if ($urandom_range(0, 9) == 0) r.bg_winner = 3'($urandom_range(5, 7));
    else r.bg_winner = 3'($urandom_range(0, 4));
    r.semi = 4'($urandom);
    for (int k = 0; k < SPRITE_LAYERS; k++) begin
      r.obj[k] = 16'($urandom);
      if (k < front) r.obj[k][PRESENT_BIT] = 1'b0;
      if (k == front) r.obj[k][PRESENT_BIT] = 1'b1;
    end
    if (front < SPRITE_LAYERS && $urandom_range(0, 3) != 0) r.semi[front] = 1'b1;
    for (int n = 0; n < BG_LAYERS; n++) begin
      r.layer[n] = 16'($urandom);
      r.layer[n][PRESENT_BIT] = ($urandom_range(0, 2) != 0);
    end
    return r;
  endfunction

  function automatic alpha_t random_alpha();
    case ($urandom_range(0, 3))
      0: return 5'd0;
      1: return 5'd16;
      2: return 5'd31;
      default: return 5'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int idle_pct;
    // --- directed table; typed expectations hold for the reset configuration
    // nothing present: background passes through
    add_pixel_row(make_req(16'h0000, 3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0,
                           16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1, 16'h0000, WIN_BACKDROP);
    // all bits set except the sprite present bits; the winner code names background 3
    add_pixel_row(make_req(16'hFFFF, 3'd4, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 4'hF,
                           16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1, 16'hFFFF, WIN_BG3);
    // front sprite ties the background's priority and wins
    add_pixel_row(make_req(16'h1234, 3'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'h0,
                           16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1, 16'hFFFF, WIN_OBJ0);
    // backdrop ranks below every sprite layer
    add_pixel_row(make_req(16'h0F0F, 3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 4'h0,
                           16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1, 16'h8000, WIN_OBJ3);
    // back sprite loses to a priority-0 background
    add_pixel_row(make_req(16'h4321, 3'd1, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 4'h0,
                           16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1, 16'h4321, WIN_BG0);
    // winner code out of range passes through unchanged
    add_pixel_row(make_req(16'h5555, 3'd7, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 4'h0,
                           16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1, 16'h5555, 4'd7);
    // and ranks like the backdrop against sprites
    add_pixel_row(make_req(16'hAAAA, 3'd5, 16'h0000, 16'h0000, 16'h8ABC, 16'h8001, 4'h0,
                           16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1, 16'h8ABC, WIN_OBJ2);
    // semi sprite with no target at reset
    add_pixel_row(make_req(16'h0000, 3'd0, 16'h0000, 16'hC63F, 16'h0000, 16'h0000, 4'hF,
                           16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0, '0, WIN_BACKDROP);
    // one background per level, all enabled, every target bit incl. the unused one,
    // both coefficients above sixteen
    add_cfg_row(CFG_BG_PRIO, 16'h00E4);
    add_cfg_row(CFG_BG_EN, 16'h000F);
    add_cfg_row(CFG_TGT_MASK, 16'h003F);
    add_cfg_row(CFG_ALPHA_A, 16'h001F);
    add_cfg_row(CFG_ALPHA_B, 16'h001F);
    add_cfg_row(CFG_BACKDROP, 16'h7FFF);
    add_pixel_row(make_req(16'h0000, 3'd1, 16'h8421, 16'h0000, 16'h0000, 16'h0000, 4'h1,
                           16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0, '0, WIN_BACKDROP);
    add_pixel_row(make_req(16'h0000, 3'd2, 16'h0000, 16'h8C63, 16'h0000, 16'h0000, 4'h2,
                           16'h0000, 16'h8842, 16'h9CE7, 16'h0000), 1'b0, '0, WIN_BACKDROP);
    // no opaque background: backdrop is the target; then a back sprite blends with its own level
    add_pixel_row(make_req(16'h0000, 3'd0, 16'h8001, 16'h0000, 16'h0000, 16'h0000, 4'h1,
                           16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF), 1'b0, '0, WIN_BACKDROP);
    add_pixel_row(make_req(16'h1111, 3'd6, 16'h0000, 16'h0000, 16'h0000, 16'h8210, 4'h8,
                           16'h8000, 16'h8000, 16'h8000, 16'h8421), 1'b0, '0, WIN_BACKDROP);
    // only the unused mask bit: no target at all
    add_cfg_row(CFG_TGT_MASK, 16'h0010);
    add_pixel_row(make_req(16'h0000, 3'd0, 16'h8123, 16'h0000, 16'h0000, 16'h0000, 4'h1,
                           16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0, '0, WIN_BACKDROP);
    // target only on the back layer: a live non-target on a deeper level stops the walk,
    // one on the sprite's own level does not
    add_cfg_row(CFG_TGT_MASK, 16'h0008);
    add_cfg_row(CFG_ALPHA_A, 16'h0000);
    add_cfg_row(CFG_ALPHA_B, 16'h0010);
    add_pixel_row(make_req(16'h0000, 3'd0, 16'h8123, 16'h0000, 16'h0000, 16'h0000, 4'h1,
                           16'h8456, 16'h8789, 16'h0000, 16'h8ABC), 1'b0, '0, WIN_BACKDROP);
    add_pixel_row(make_req(16'h0000, 3'd0, 16'h8123, 16'h0000, 16'h0000, 16'h0000, 4'h1,
                           16'h8456, 16'h0789, 16'h0000, 16'h8ABC), 1'b0, '0, WIN_BACKDROP);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (start) drain_pixels();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        send_pixel(directed_rows[i].req, 0, directed_rows[i].has_exp, directed_rows[i].exp);
      end
    end

    // --- random phases: fresh register set each phase, sender idling rotates
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) configure(8'hFF, 4'hF, 6'h3F, 5'd31, 5'd31, 16'hFFFF);
      else if (ph == 1) configure(8'h00, 4'h0, 6'h00, 5'd0, 5'd0, 16'h0000);
      else configure(8'($urandom), 4'($urandom), 6'($urandom), random_alpha(), random_alpha(),
                     16'($urandom));
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 51 : 32;
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        send_pixel(random_pixel(), idle_pct, 1'b0, '0);
    end

    drain_pixels();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
